FILE: src/afrc_pkg.sv
package afrc_pkg;

  localparam logic [7:0] StartDelim = 8'h7E;
  localparam logic [7:0] SumGood    = 8'hFF;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_CKSUM     = 2'd1,
    ST_BADID     = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  typedef enum logic {
    CFG_EXPECTED_ID = 1'b0,
    CFG_CODE_POS    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] seen_frame_id;
    logic [7:0] frame_type;
    logic [7:0] response_code;
    status_e    status;
  } result_t;

endpackage

FILE: src/api_frame_response_checker.sv
// channel    dir  word layout (lsb up)                                       
// s_axis     in   tdata[7:0] rx_byte                                         
// m_axis     out  tdata[1:0] status, [9:2] response_code, [17:10] frame_type,
//                 [25:18] seen_frame_id, [31:26] zero                        
// cfg        in   cfg_we_i / cfg_idx_i / cfg_wdata_i, no read-back           
//
// a byte is accepted every cycle it is not held off; its state update is one
// add and a few compares between the state registers and the result register
// a result shows up in the cycle after its checksum byte is accepted
// only a checksum byte is held off while an earlier result is stalled; all
// other bytes keep flowing into the parser
// rst_ni clears the parser to hunting, registers to id 0 and code position 1
module api_frame_response_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side, tdata: rx_byte
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // master side, tdata: status, response_code, frame_type, seen_frame_id, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  // configuration registers
  logic [7:0] exp_id_q, code_pos_q;

  // parser state
  afrc_pkg::phase_e phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  code_q, code_d;
  logic        captured_q, captured_d;

  // result register
  logic                out_valid_q, out_valid_d;
  afrc_pkg::result_t   out_q, out_d;

  logic       accept;
  logic       csum_next;   // the next byte to arrive is the checksum
  logic [7:0] sum_add;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign csum_next = (phase_q == afrc_pkg::PH_BODY) && (idx_q == len_q);
  assign sum_add   = sum_q + s_axis_tdata;

  // outputs
  always_comb begin
    s_axis_tready = !csum_next || !out_valid_q || m_axis_tready;
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = out_q;
  end

  // next state and datapath
  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    type_d      = type_q;
    id_d        = id_q;
    code_d      = code_q;
    captured_d  = captured_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;

    if (accept) begin
      unique case (phase_q)
        afrc_pkg::PH_HUNT: begin
          if (s_axis_tdata == afrc_pkg::StartDelim) begin
            phase_d    = afrc_pkg::PH_LEN_HI;
            len_d      = '0;
            idx_d      = '0;
            sum_d      = '0;
            type_d     = '0;
            id_d       = '0;
            code_d     = '0;
            captured_d = 1'b0;
          end
        end
        afrc_pkg::PH_LEN_HI: begin
          len_d   = {s_axis_tdata, 8'h00};
          phase_d = afrc_pkg::PH_LEN_LO;
        end
        afrc_pkg::PH_LEN_LO: begin
          len_d   = {len_q[15:8], s_axis_tdata};
          idx_d   = '0;
          phase_d = afrc_pkg::PH_BODY;
        end
        afrc_pkg::PH_BODY: begin
          sum_d = sum_add;
          if (!csum_next) begin
            // frame data byte: pick off type, id and the code byte
            if (idx_q == 16'd0) type_d = s_axis_tdata;
            if (idx_q == 16'd1) id_d = s_axis_tdata;
            if (idx_q == {8'h00, code_pos_q}) begin
              code_d     = s_axis_tdata;
              captured_d = 1'b1;
            end
            idx_d = idx_q + 16'd1;
          end else begin
            // checksum byte closes the frame
            out_valid_d         = 1'b1;
            out_d.pad           = '0;
            out_d.response_code = code_q;
            out_d.frame_type    = type_q;
            out_d.seen_frame_id = id_q;
            priority if (len_q < 16'd2 || !captured_q) begin
              out_d.status = afrc_pkg::ST_MALFORMED;
            end else if (sum_add != afrc_pkg::SumGood) begin
              out_d.status = afrc_pkg::ST_CKSUM;
            end else if (id_q != exp_id_q) begin
              out_d.status = afrc_pkg::ST_BADID;
            end else begin
              out_d.status = afrc_pkg::ST_GOOD;
            end
            phase_d    = afrc_pkg::PH_HUNT;
            len_d      = '0;
            idx_d      = '0;
            sum_d      = '0;
            type_d     = '0;
            id_d       = '0;
            code_d     = '0;
            captured_d = 1'b0;
          end
        end
        default: phase_d = afrc_pkg::PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q    <= 8'd0;
      code_pos_q  <= 8'd1;
      phase_q     <= afrc_pkg::PH_HUNT;
      len_q       <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      type_q      <= '0;
      id_q        <= '0;
      code_q      <= '0;
      captured_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (afrc_pkg::cfg_idx_e'(cfg_idx_i))
          afrc_pkg::CFG_EXPECTED_ID: exp_id_q   <= cfg_wdata_i;
          afrc_pkg::CFG_CODE_POS:    code_pos_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      phase_q     <= phase_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      type_q      <= type_d;
      id_q        <= id_d;
      code_q      <= code_d;
      captured_q  <= captured_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

FILE: src/afrc_checker.sv
module afrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // pad bits of the result word are zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:26] == 6'd0)
    else $error("result pad bits not zero");

  // input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // no result appears without an accepted byte
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("result appeared with no input");

endmodule

bind api_frame_response_checker afrc_checker u_afrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/frame_verdict_monitor.sv
module frame_verdict_monitor
  import afrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_data_i,    // [7:0] rx_byte
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [31:0] res_data_i,   // status, response_code, frame_type, seen_frame_id, pad
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output int          mismatches_o,
  output int          pending_o,
  output logic        hunting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the parser
  phase_e      phase_q;
  logic [15:0] frame_len;
  logic [15:0] data_idx;
  logic [7:0]  run_sum;
  logic [7:0]  kept_type;
  logic [7:0]  kept_id;
  logic [7:0]  kept_code;
  logic        code_seen;

  // shadow of the registers
  logic [7:0]  want_id;
  logic [7:0]  code_pos;

  result_t     verdicts[$];
  int          mismatches;

  task automatic clear_frame();
    frame_len = '0;
    data_idx  = '0;
    run_sum   = '0;
    kept_type = '0;
    kept_id   = '0;
    kept_code = '0;
    code_seen = 1'b0;
  endtask

  // advance the shadow parser by one byte, queue a verdict on a checksum byte
  task automatic absorb_rx_byte(input logic [7:0] b);
    result_t v;
    v = '0;
    case (phase_q)
      PH_HUNT: begin
        if (b == StartDelim) begin
          clear_frame();
          phase_q = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        frame_len = {b, 8'h00};
        phase_q   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len[7:0] = b;
        data_idx       = '0;
        phase_q        = PH_BODY;
      end
      default: begin
        run_sum = run_sum + b;
        if (data_idx < frame_len) begin
          if (data_idx == 16'd0) kept_type = b;
          if (data_idx == 16'd1) kept_id = b;
          if (data_idx == {8'h00, code_pos}) begin
            kept_code = b;
            code_seen = 1'b1;
          end
          data_idx = data_idx + 16'd1;
        end else begin
          if (frame_len < 16'd2 || !code_seen) v.status = ST_MALFORMED;
          else if (run_sum != SumGood)        v.status = ST_CKSUM;
          else if (kept_id != want_id)        v.status = ST_BADID;
          else                                v.status = ST_GOOD;
          v.response_code = code_seen ? kept_code : 8'h00;
          v.frame_type    = kept_type;
          v.seen_frame_id = kept_id;
          verdicts.push_back(v);
          phase_q = PH_HUNT;
          clear_frame();
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      phase_q    = PH_HUNT;
      clear_frame();
      want_id    = 8'h00;
      code_pos   = 8'h01;
      verdicts.delete();
      mismatches = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      hunting_o    <= 1'b1;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got = res_data_i;
        if (verdicts.size() == 0) begin
          mismatches++;
          $display("%0t unexpected word: expected none actual %0h", $time, res_data_i);
        end else begin
          want = verdicts.pop_front();
          check_field("status", {6'b0, want.status}, {6'b0, got.status});
          check_field("response_code", want.response_code, got.response_code);
          check_field("frame_type", want.frame_type, got.frame_type);
          check_field("seen_frame_id", want.seen_frame_id, got.seen_frame_id);
          check_field("pad", {2'b0, want.pad}, {2'b0, got.pad});
        end
      end
      if (rx_valid_i && rx_ready_i) absorb_rx_byte(rx_data_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_EXPECTED_ID) want_id = cfg_wdata_i;
        else                              code_pos = cfg_wdata_i;
      end
      mismatches_o <= mismatches;
      pending_o    <= verdicts.size();
      hunting_o    <= (phase_q == PH_HUNT);
    end
  end

endmodule

FILE: tb/tb.sv
module tb;
  import afrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles to let pass after the last verdict before touching registers
  localparam int DrainCycles = 4;
  // one long receiver hold-off so the checksum byte backs up the input
  localparam int LongHold    = 400;
  // frame words per random phase, six phases in all
  localparam int PhaseWords  = 240;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [1:0] status, [9:2] response_code, [17:10] frame_type,
                               // [25:18] seen_frame_id, [31:26] pad
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;

  int          mismatches;
  int          pending;
  logic        parser_hunting;

  // sender burst state and words sent inside frames
  int          burst_left;
  int          frame_words;
  // handshake between stimulus and receiver for the long hold-off
  bit          hold_req;
  bit          hold_done;

  api_frame_response_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  frame_verdict_monitor verdict_mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (s_axis_tvalid),
    .rx_ready_i   (s_axis_tready),
    .rx_data_i    (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .hunting_o    (parser_hunting)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // offer one word; bursts of random length separated by random gaps,
  // a gap of zero keeps tvalid high across the burst boundary
  task automatic offer_word(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // delimiter, big-endian length, data and checksum; a cut at or above zero
  // stops after that many data bytes and leaves the checksum out
  task automatic send_frame(input logic [15:0] len, input logic [7:0] ftype,
                            input logic [7:0] fid, input bit sum_ok, input int cut);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    n   = (cut < 0) ? int'(len) : cut;
    sum = 8'h00;
    offer_word(StartDelim);
    offer_word(len[15:8]);
    offer_word(len[7:0]);
    for (int i = 0; i < n; i++) begin
      b = (i == 0) ? ftype : (i == 1) ? fid : 8'($urandom_range(0, 255));
      sum = sum + b;
      offer_word(b);
    end
    // a bad checksum is always off by a nonzero pattern
    if (cut < 0) begin
      offer_word(sum_ok ? (SumGood - sum) : ((SumGood - sum) ^ 8'($urandom_range(1, 255))));
    end
    frame_words += n + ((cut < 0) ? 4 : 3);
  endtask

  // wait for all verdicts plus a few cycles; a partial frame left in the
  // parser is pushed through with filler until it ends, then wait again
  task automatic settle_parser();
    bit idle;
    idle = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (!idle) begin
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
      if (parser_hunting) begin
        idle = 1'b1;
      end else begin
        while (!parser_hunting) begin
          offer_word(8'h00);
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
        end
      end
    end
  endtask

  // both registers, one write per cycle, only while the parser is idle
  task automatic load_registers(input logic [7:0] eid, input logic [7:0] cpos);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_EXPECTED_ID;
    cfg_wdata_i <= eid;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CODE_POS;
    cfg_wdata_i <= cpos;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly well-formed frames with random content, some line noise,
  // bad checksums, foreign ids and the odd truncated frame
  task automatic run_traffic(input logic [7:0] eid, input int target);
    int         pick;
    int         cut;
    int         nnoise;
    logic [15:0] len;
    logic [7:0]  fid;
    logic [7:0]  nb;
    frame_words = 0;
    while (frame_words < target) begin
      if ($urandom_range(0, 99) < 15) begin
        nnoise = $urandom_range(1, 3);
        repeat (nnoise) begin
          nb = 8'($urandom_range(0, 255));
          if (nb == StartDelim) nb = 8'h00;
          offer_word(nb);
        end
      end
      // short frames dominate, a few cross the 256 byte mark
      pick = $urandom_range(0, 99);
      if (pick < 85)      len = 16'($urandom_range(0, 12));
      else if (pick < 97) len = 16'($urandom_range(13, 40));
      else                len = 16'($urandom_range(256, 300));
      fid = ($urandom_range(0, 9) < 6) ? eid : 8'($urandom_range(0, 255));
      cut = (len <= 16'd12 && $urandom_range(0, 49) == 0) ? $urandom_range(0, int'(len)) : -1;
      send_frame(len, 8'($urandom_range(0, 255)), fid, ($urandom_range(0, 9) < 7), cut);
    end
  endtask

  // stimulus
  initial begin
    logic [7:0] eid;
    logic [7:0] cpos;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_EXPECTED_ID;
    cfg_wdata_i   <= 8'h00;
    burst_left    = 0;
    frame_words   = 0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, at reset register values (expected id 0, code at byte 1)
    offer_word(8'h00);                          // noise skipped while hunting
    offer_word(8'hFF);
    send_frame(16'd0, 8'h00, 8'h00, 1'b1, -1);  // zero length, checksum follows length
    send_frame(16'd1, 8'h10, 8'h00, 1'b1, -1);  // single byte, no frame id
    send_frame(16'd2, 8'h88, 8'h00, 1'b1, -1);  // good frame
    send_frame(16'd3, 8'h7E, 8'h00, 1'b0, -1);  // delimiter as data, bad sum
    send_frame(16'd2, 8'hFF, 8'hFF, 1'b1, -1);  // foreign id, all ones

    // random phases over several register settings, extremes first
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          eid  = 8'hFF;
          cpos = 8'h00;
        end
        1: begin
          eid  = 8'h00;
          cpos = 8'hFF;
        end
        2: begin
          eid  = 8'hA5;
          cpos = 8'h02;
        end
        default: begin
          eid  = 8'($urandom_range(0, 255));
          cpos = 8'($urandom_range(0, 15));
        end
      endcase
      settle_parser();
      load_registers(eid, cpos);
      // long hold-off lands while the first random phase is streaming
      if (p == 0) hold_req = 1'b1;
      run_traffic(eid, PhaseWords);
    end

    settle_parser();
    repeat (2 * DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS api_frame_response_checker");
    end else begin
      $display("FAIL api_frame_response_checker");
    end
    $finish;
  end

  // receiver: random stall patterns, plus one long hold-off early in the
  // random part while the sender keeps offering
  initial begin : receiver
    int mode;
    int span;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 60);
      repeat (span) begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 5) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
        @(posedge clk_i);
      end
    end
  end

  // run limit
  initial begin
    #8000000;
    $display("FAIL api_frame_response_checker");
    $finish;
  end

endmodule
